/* design/uri_local_classifier_macros.svh */
// assertion macros for the uri local classifier checker
// depends on nothing; included by the checker file only
`ifndef URI_LOCAL_CLASSIFIER_MACROS_SVH
`define URI_LOCAL_CLASSIFIER_MACROS_SVH

// same-cycle implication, sampled on the rising clock, off during reset
`define ULC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on the rising clock, off during reset
`define ULC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/ulc_pkg.sv */
// shared types, string tables and helpers for the uri local classifier
// no dependencies; imported by the top level and by the checker
`default_nettype none

package ulc_pkg;

    // parse phase of the current uri
    typedef enum logic [2:0] {
        PH_SCHEME = 3'd0,
        PH_SLASH1 = 3'd1,
        PH_SLASH2 = 3'd2,
        PH_HOST   = 3'd3,
        PH_DONE   = 3'd4
    } phase_t;

    // verdict reason
    typedef enum logic [2:0] {
        REASON_BAD_SCHEME = 3'd0,
        REASON_INTERNAL   = 3'd1,
        REASON_LOCAL_HOST = 3'd2,
        REASON_REMOTE     = 3'd3,
        REASON_OTHER      = 3'd4,
        REASON_BAD_AUTH   = 3'd5
    } reason_t;

    localparam int NUM_SCHEMES = 6;
    localparam int NUM_HOSTS   = 3;

    // scheme order: about, data, blob, ev, http, https
    localparam logic [7:0] SCHEME_TBL [0:NUM_SCHEMES-1][0:7] = '{
        '{"a", "b", "o", "u", "t", 8'h00, 8'h00, 8'h00},
        '{"d", "a", "t", "a", 8'h00, 8'h00, 8'h00, 8'h00},
        '{"b", "l", "o", "b", 8'h00, 8'h00, 8'h00, 8'h00},
        '{"e", "v", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"h", "t", "t", "p", 8'h00, 8'h00, 8'h00, 8'h00},
        '{"h", "t", "t", "p", "s", 8'h00, 8'h00, 8'h00}
    };
    localparam logic [3:0] SCHEME_LEN [0:NUM_SCHEMES-1] = '{
        4'd5, 4'd4, 4'd4, 4'd2, 4'd4, 4'd5
    };
    localparam logic [NUM_SCHEMES-1:0] SCHEME_INTERNAL_MASK = 6'b001111;
    localparam logic [NUM_SCHEMES-1:0] SCHEME_WEB_MASK      = 6'b110000;

    // host order: assets, local, lister
    localparam logic [7:0] HOST_TBL [0:NUM_HOSTS-1][0:15] = '{
        '{"a", "s", "s", "e", "t", "s", ".", "e", "x", "a", "m", "p", "l", "e",
          8'h00, 8'h00},
        '{"l", "o", "c", "a", "l", ".", "e", "x", "a", "m", "p", "l", "e",
          8'h00, 8'h00, 8'h00},
        '{"l", "i", "s", "t", "e", "r", ".", "e", "x", "a", "m", "p", "l", "e",
          8'h00, 8'h00}
    };
    localparam logic [3:0] HOST_LEN [0:NUM_HOSTS-1] = '{4'd14, 4'd13, 4'd14};

    // fold upper-case ascii letters to lower case
    function automatic logic [7:0] to_lower(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c inside {["A":"Z"]})
        begin
            r = c + 8'd32;
        end
        return r;
    endfunction

    // local host if a surviving candidate has exactly the host length
    function automatic reason_t host_verdict(input logic [NUM_HOSTS-1:0] cand,
                                             input logic [3:0] pos);
        reason_t r;
        r = REASON_REMOTE;
        for (int k = 0; k < NUM_HOSTS; k++)
        begin
            if (cand[k] && (HOST_LEN[k] == pos))
            begin
                r = REASON_LOCAL_HOST;
            end
        end
        return r;
    endfunction

endpackage

`default_nettype wire

/* design/uri_local_classifier.sv */
// uri local classifier top level: byte stream in, one verdict per uri out
// depends on ulc_pkg for phase and reason types and the string tables
//
// channel   dir  tdata                          tlast     tuser
// s_axis    in   [7:0] char_byte                is_last   end_only
// m_axis    out  [0] is_local, [3:1] reason     -         -
//
// one transaction per cycle sustained; each byte is parsed while it sits
// in the input register, and an ending one loads the output register
// a verdict is valid once its ending transaction has passed from the input register into the output register;
// rst_n clears the parse state and both valid flags; no clearing pass
// a verdict held by m_axis_tready low stalls only an ending transaction
// in the input register; non-ending transactions keep flowing
`default_nettype none

module uri_local_classifier (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       s_axis_tvalid,
    output logic            s_axis_tready,
    input  wire logic [7:0] s_axis_tdata,   // [7:0] char_byte
    input  wire logic       s_axis_tlast,   // is_last
    input  wire logic       s_axis_tuser,   // [0] end_only
    output logic            m_axis_tvalid,
    input  wire logic       m_axis_tready,
    output logic [7:0]      m_axis_tdata    // [0] is_local, [3:1] reason_code, [7:4] zero
);
    import ulc_pkg::*;

    // input register
    logic        in_valid_reg, in_valid_next;
    logic [7:0]  in_byte_reg;
    logic        in_last_reg;
    logic        in_end_reg;

    // parse state
    phase_t                 phase_reg, phase_next;
    logic [3:0]             pos_reg, pos_next;
    logic [NUM_SCHEMES-1:0] scand_reg, scand_next;
    logic [NUM_HOSTS-1:0]   hcand_reg, hcand_next;
    reason_t                verdict_reg, verdict_next;

    // output register
    logic        out_valid_reg, out_valid_next;
    logic [7:0]  out_data_reg;

    // step signals
    logic                   ends_uri;
    logic                   out_free;
    logic                   step_fire;
    logic                   load_out;
    logic [7:0]             lc;
    logic                   scheme_ok;
    logic [NUM_SCHEMES-1:0] exact;
    logic [3:0]             pos_inc;
    reason_t                end_code;
    logic                   end_local;

    // handshake and stall control
    assign ends_uri      = in_last_reg || in_end_reg;
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign step_fire     = in_valid_reg && (!ends_uri || out_free);
    assign load_out      = step_fire && ends_uri;
    assign s_axis_tready = !in_valid_reg || step_fire;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    // character classes for the current byte
    assign lc      = to_lower(in_byte_reg);
    assign pos_inc = (pos_reg == 4'd15) ? pos_reg : pos_reg + 4'd1;
    always_comb
    begin
        scheme_ok = (in_byte_reg inside {["a":"z"], ["A":"Z"]}) ||
                    ((pos_reg != 4'd0) &&
                     (in_byte_reg inside {["0":"9"], "+", "-", "."}));
        for (int k = 0; k < NUM_SCHEMES; k++)
        begin
            exact[k] = scand_reg[k] && (SCHEME_LEN[k] == pos_reg);
        end
    end

    // next parse state for one byte
    always_comb
    begin
        phase_next   = phase_reg;
        pos_next     = pos_reg;
        scand_next   = scand_reg;
        hcand_next   = hcand_reg;
        verdict_next = verdict_reg;
        if (!in_end_reg)
        begin
            case (phase_reg)
                PH_SCHEME:
                begin
                    if (in_byte_reg == ":")
                    begin
                        if (pos_reg == 4'd0)
                        begin
                            phase_next   = PH_DONE;
                            verdict_next = REASON_BAD_SCHEME;
                        end
                        else if ((exact & SCHEME_INTERNAL_MASK) != '0)
                        begin
                            phase_next   = PH_DONE;
                            verdict_next = REASON_INTERNAL;
                        end
                        else if ((exact & SCHEME_WEB_MASK) != '0)
                        begin
                            phase_next = PH_SLASH1;
                        end
                        else
                        begin
                            phase_next   = PH_DONE;
                            verdict_next = REASON_OTHER;
                        end
                    end
                    else if (!scheme_ok)
                    begin
                        phase_next   = PH_DONE;
                        verdict_next = REASON_BAD_SCHEME;
                    end
                    else
                    begin
                        for (int k = 0; k < NUM_SCHEMES; k++)
                        begin
                            if (!((pos_reg < SCHEME_LEN[k]) &&
                                  (SCHEME_TBL[k][pos_reg[2:0]] == lc)))
                            begin
                                scand_next[k] = 1'b0;
                            end
                        end
                        pos_next = pos_inc;
                    end
                end
                PH_SLASH1:
                begin
                    if (in_byte_reg == "/")
                    begin
                        phase_next = PH_SLASH2;
                    end
                    else
                    begin
                        phase_next   = PH_DONE;
                        verdict_next = REASON_BAD_AUTH;
                    end
                end
                PH_SLASH2:
                begin
                    if (in_byte_reg == "/")
                    begin
                        phase_next = PH_HOST;
                        pos_next   = 4'd0;
                        hcand_next = '1;
                    end
                    else
                    begin
                        phase_next   = PH_DONE;
                        verdict_next = REASON_BAD_AUTH;
                    end
                end
                PH_HOST:
                begin
                    if (in_byte_reg inside {"/", "?", "#", ":"})
                    begin
                        phase_next   = PH_DONE;
                        verdict_next = host_verdict(hcand_reg, pos_reg);
                    end
                    else
                    begin
                        for (int k = 0; k < NUM_HOSTS; k++)
                        begin
                            if (!((pos_reg < HOST_LEN[k]) &&
                                  (HOST_TBL[k][pos_reg] == lc)))
                            begin
                                hcand_next[k] = 1'b0;
                            end
                        end
                        pos_next = pos_inc;
                    end
                end
                default:
                begin
                    phase_next = phase_reg;
                end
            endcase
        end
    end

    // verdict for a uri that ends with this transaction
    always_comb
    begin
        case (phase_next)
            PH_SCHEME: end_code = REASON_BAD_SCHEME;
            PH_SLASH1: end_code = REASON_BAD_AUTH;
            PH_SLASH2: end_code = REASON_BAD_AUTH;
            PH_HOST:   end_code = host_verdict(hcand_next, pos_next);
            default:   end_code = verdict_next;
        endcase
        end_local = (end_code == REASON_INTERNAL) || (end_code == REASON_LOCAL_HOST);
    end

    // valid flags
    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (s_axis_tready)
        begin
            in_valid_next = s_axis_tvalid;
        end
        out_valid_next = out_valid_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // input payload
    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_byte_reg <= s_axis_tdata;
            in_last_reg <= s_axis_tlast;
            in_end_reg  <= s_axis_tuser;
        end
    end

    // parse state, back to reset values after each verdict
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_SCHEME;
            pos_reg     <= 4'd0;
            scand_reg   <= '1;
            hcand_reg   <= '1;
            verdict_reg <= REASON_BAD_SCHEME;
        end
        else if (load_out)
        begin
            phase_reg   <= PH_SCHEME;
            pos_reg     <= 4'd0;
            scand_reg   <= '1;
            hcand_reg   <= '1;
            verdict_reg <= REASON_BAD_SCHEME;
        end
        else if (step_fire)
        begin
            phase_reg   <= phase_next;
            pos_reg     <= pos_next;
            scand_reg   <= scand_next;
            hcand_reg   <= hcand_next;
            verdict_reg <= verdict_next;
        end
    end

    // output payload
    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_data_reg <= {4'b0000, end_code, end_local};
        end
    end

endmodule

`default_nettype wire

/* design/ulc_checker.sv */
// port-level checker for the uri local classifier, bound to the top level
// depends on ulc_pkg and uri_local_classifier_macros.svh
`default_nettype none
`include "uri_local_classifier_macros.svh"

module ulc_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       s_axis_tvalid,
    input wire logic       s_axis_tready,
    input wire logic [7:0] s_axis_tdata,
    input wire logic       s_axis_tlast,
    input wire logic       s_axis_tuser,
    input wire logic       m_axis_tvalid,
    input wire logic       m_axis_tready,
    input wire logic [7:0] m_axis_tdata
);
    import ulc_pkg::*;

    logic    in_end_txn;
    reason_t out_code;

    assign in_end_txn = s_axis_tvalid && s_axis_tready && (s_axis_tlast || s_axis_tuser);
    assign out_code   = reason_t'(m_axis_tdata[3:1]);

    // a held verdict stays valid until taken
    `ULC_ASSERT_NEXT(a_out_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid, "verdict dropped before transaction")

    // is_local follows the reason code
    `ULC_ASSERT_NOW(a_local_match, clk, rst_n, m_axis_tvalid, m_axis_tdata[0] == ((out_code == REASON_INTERNAL) || (out_code == REASON_LOCAL_HOST)), "is_local disagrees with reason")

    // reason code in range and padding zero
    `ULC_ASSERT_NOW(a_code_range, clk, rst_n, m_axis_tvalid, (m_axis_tdata[3:1] != 3'd6) && (m_axis_tdata[3:1] != 3'd7) && (m_axis_tdata[7:4] == 4'd0), "bad verdict encoding")

    // a new verdict follows an accepted ending transaction through the input and output registers
    `ULC_ASSERT_NOW(a_out_cause, clk, rst_n, m_axis_tvalid && !$past(m_axis_tvalid), $past(in_end_txn, 2), "verdict without ending transaction")

endmodule

bind uri_local_classifier ulc_checker u_ulc_checker (.*);

`default_nettype wire
